// ===== src/ptp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Priority table package
// Shared constants, codes and control/status types of the priority table.
// ----------------------------------------------------------------------------
package ptp_pkg;

    localparam int DEPTH         = 256;
    localparam int ADDR_BITS     = $clog2(DEPTH);
    localparam int CNT_BITS      = ADDR_BITS + 1;
    localparam int PAYLOAD_BITS  = 32;
    localparam int PRIORITY_BITS = 16;

    localparam logic [2:0] OP_ADD      = 3'd0;
    localparam logic [2:0] OP_PROMOTE  = 3'd1;
    localparam logic [2:0] OP_GET      = 3'd2;
    localparam logic [2:0] OP_IS_VALID = 3'd3;
    localparam logic [2:0] OP_GET_MAX  = 3'd4;
    localparam logic [2:0] OP_POP_MAX  = 3'd5;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    localparam logic [1:0] RD_ID   = 2'd0;
    localparam logic [1:0] RD_SCAN = 2'd1;
    localparam logic [1:0] RD_BEST = 2'd2;

    localparam logic [3:0] RSP_ADD_OK     = 4'd0;
    localparam logic [3:0] RSP_FULL       = 4'd1;
    localparam logic [3:0] RSP_BAD_ID     = 4'd2;
    localparam logic [3:0] RSP_BAD_OP     = 4'd3;
    localparam logic [3:0] RSP_PROMOTE    = 4'd4;
    localparam logic [3:0] RSP_GET        = 4'd5;
    localparam logic [3:0] RSP_VALID      = 4'd6;
    localparam logic [3:0] RSP_EMPTY      = 4'd7;
    localparam logic [3:0] RSP_MAX        = 4'd8;

    typedef struct packed {
        logic       load;
        logic       add_commit;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       prio_wr;
        logic       scan_init;
        logic       scan_step;
        logic       pop_clear;
        logic       respond;
        logic [3:0] resp_sel;
    } cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       full;
        logic       id_live;
        logic       scan_last;
        logic       found;
    } stat_t;

endpackage

// ===== src/priority_table_with_promote_core.sv =====
`timescale 1ns / 1ps
// The done strobe follows the decode state for add, is_valid and bad requests, the
// read state for promote and get, and the scan, drain, fetch and max-out states
// for get_max and pop_max (fetch when empty). Busy drops in the done cycle; a new
// request is taken only while idle. The max scan reads one priority per cycle.
// Reset clears the id counter and all live flags at once; no clearing pass.
// The receiver cannot stall: done is high for a single cycle per result.
// ----------------------------------------------------------------------------
// Priority table core
// Indexed max-priority table with add, promote, get, is_valid and max/pop.
// ----------------------------------------------------------------------------
module priority_table_with_promote_core
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [2:0]                          opcode,
    input  logic [ptp_pkg::ADDR_BITS-1:0]       entry_id,
    input  logic [ptp_pkg::PAYLOAD_BITS-1:0]    payload_in,
    output logic                                done,
    output logic [1:0]                          status,
    output logic [ptp_pkg::ADDR_BITS-1:0]       result_id,
    output logic [ptp_pkg::PAYLOAD_BITS-1:0]    payload_out,
    output logic [ptp_pkg::PRIORITY_BITS-1:0]   priority_out,
    output logic                                is_live
);

    ptp_pkg::cmd_t  cmd;
    ptp_pkg::stat_t stat;

    ptp_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    ptp_datapath u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .opcode       (opcode),
        .entry_id     (entry_id),
        .payload_in   (payload_in),
        .done         (done),
        .status       (status),
        .result_id    (result_id),
        .payload_out  (payload_out),
        .priority_out (priority_out),
        .is_live      (is_live)
    );

endmodule

// ===== src/ptp_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Priority table datapath
// Payload and priority memories, live flags, id counter, max scan and
// result registers.
// ----------------------------------------------------------------------------
module ptp_datapath
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  ptp_pkg::cmd_t                       cmd,
    output ptp_pkg::stat_t                      stat,
    input  logic [2:0]                          opcode,
    input  logic [ptp_pkg::ADDR_BITS-1:0]       entry_id,
    input  logic [ptp_pkg::PAYLOAD_BITS-1:0]    payload_in,
    output logic                                done,
    output logic [1:0]                          status,
    output logic [ptp_pkg::ADDR_BITS-1:0]       result_id,
    output logic [ptp_pkg::PAYLOAD_BITS-1:0]    payload_out,
    output logic [ptp_pkg::PRIORITY_BITS-1:0]   priority_out,
    output logic                                is_live
);

    logic [2:0]                          op_reg;
    logic [ptp_pkg::ADDR_BITS-1:0]       id_reg;
    logic [ptp_pkg::PAYLOAD_BITS-1:0]    pay_in_reg;
    logic [ptp_pkg::CNT_BITS-1:0]        next_id_reg;
    logic [ptp_pkg::DEPTH-1:0]           live_reg;

    logic [ptp_pkg::PAYLOAD_BITS-1:0]    pay_mem [ptp_pkg::DEPTH];
    logic [ptp_pkg::PRIORITY_BITS-1:0]   prio_mem [ptp_pkg::DEPTH];
    logic [ptp_pkg::PAYLOAD_BITS-1:0]    pay_rd_reg;
    logic [ptp_pkg::PRIORITY_BITS-1:0]   prio_rd_reg;

    logic [ptp_pkg::ADDR_BITS-1:0]       scan_addr_reg;
    logic                                cmp_valid_reg;
    logic                                cmp_live_reg;
    logic [ptp_pkg::ADDR_BITS-1:0]       cmp_idx_reg;
    logic                                found_reg;
    logic [ptp_pkg::ADDR_BITS-1:0]       best_id_reg;
    logic [ptp_pkg::PRIORITY_BITS-1:0]   best_prio_reg;

    logic                                done_reg;
    logic [1:0]                          status_reg, status_next;
    logic [ptp_pkg::ADDR_BITS-1:0]       result_id_reg, result_id_next;
    logic [ptp_pkg::PAYLOAD_BITS-1:0]    payload_out_reg, payload_out_next;
    logic [ptp_pkg::PRIORITY_BITS-1:0]   priority_out_reg, priority_out_next;
    logic                                is_live_reg, is_live_next;

    logic [ptp_pkg::ADDR_BITS-1:0]       wr_addr;
    logic [ptp_pkg::ADDR_BITS-1:0]       rd_addr;
    logic [ptp_pkg::PRIORITY_BITS-1:0]   prio_inc;
    logic [ptp_pkg::PRIORITY_BITS-1:0]   prio_wdata;
    logic                                id_live;

    assign id_live  = ({1'b0, id_reg} < next_id_reg) && live_reg[id_reg];
    assign prio_inc = (prio_rd_reg == {ptp_pkg::PRIORITY_BITS{1'b1}})
                      ? prio_rd_reg
                      : prio_rd_reg + {{(ptp_pkg::PRIORITY_BITS-1){1'b0}}, 1'b1};
    assign wr_addr    = cmd.add_commit ? next_id_reg[ptp_pkg::ADDR_BITS-1:0] : id_reg;
    assign prio_wdata = cmd.add_commit ? '0 : prio_inc;

    always_comb
    begin
        unique case (cmd.rd_sel)
            ptp_pkg::RD_SCAN: rd_addr = scan_addr_reg;
            ptp_pkg::RD_BEST: rd_addr = best_id_reg;
            default:          rd_addr = id_reg;
        endcase
    end

    assign stat.op        = op_reg;
    assign stat.full      = (next_id_reg == ptp_pkg::CNT_BITS'(ptp_pkg::DEPTH));
    assign stat.id_live   = id_live;
    assign stat.scan_last = (scan_addr_reg == ptp_pkg::ADDR_BITS'(ptp_pkg::DEPTH - 1));
    assign stat.found     = found_reg;

    // request latch
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= opcode;
            id_reg     <= entry_id;
            pay_in_reg <= payload_in;
        end
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (cmd.add_commit)
        begin
            pay_mem[wr_addr] <= pay_in_reg;
        end
        if (cmd.add_commit || cmd.prio_wr)
        begin
            prio_mem[wr_addr] <= prio_wdata;
        end
        if (cmd.rd_en)
        begin
            pay_rd_reg  <= pay_mem[rd_addr];
            prio_rd_reg <= prio_mem[rd_addr];
        end
    end

    // id counter and live flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_id_reg <= '0;
            live_reg    <= '0;
        end
        else
        begin
            if (cmd.add_commit)
            begin
                next_id_reg <= next_id_reg + {{(ptp_pkg::CNT_BITS-1){1'b0}}, 1'b1};
                live_reg[next_id_reg[ptp_pkg::ADDR_BITS-1:0]] <= 1'b1;
            end
            if (cmd.pop_clear)
            begin
                live_reg[best_id_reg] <= 1'b0;
            end
        end
    end

    // max scan: issue one read per cycle, compare in the next cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_addr_reg <= '0;
            cmp_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            cmp_valid_reg <= cmd.scan_step;
            if (cmd.scan_init)
            begin
                scan_addr_reg <= '0;
                found_reg     <= 1'b0;
            end
            else
            begin
                if (cmd.scan_step)
                begin
                    scan_addr_reg <= scan_addr_reg + {{(ptp_pkg::ADDR_BITS-1){1'b0}}, 1'b1};
                end
                if (cmp_valid_reg && cmp_live_reg &&
                    (!found_reg || prio_rd_reg >= best_prio_reg))
                begin
                    found_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_step)
        begin
            cmp_live_reg <= live_reg[scan_addr_reg];
            cmp_idx_reg  <= scan_addr_reg;
        end
        if (!cmd.scan_init && cmp_valid_reg && cmp_live_reg &&
            (!found_reg || prio_rd_reg >= best_prio_reg))
        begin
            best_id_reg   <= cmp_idx_reg;
            best_prio_reg <= prio_rd_reg;
        end
    end

    // result select
    always_comb
    begin
        status_next       = ptp_pkg::ST_OK;
        result_id_next    = '0;
        payload_out_next  = '0;
        priority_out_next = '0;
        is_live_next      = 1'b0;
        unique case (cmd.resp_sel)
            ptp_pkg::RSP_ADD_OK:
            begin
                result_id_next = next_id_reg[ptp_pkg::ADDR_BITS-1:0];
            end
            ptp_pkg::RSP_FULL:
            begin
                status_next = ptp_pkg::ST_FULL;
            end
            ptp_pkg::RSP_BAD_ID:
            begin
                status_next    = ptp_pkg::ST_INVALID;
                result_id_next = id_reg;
            end
            ptp_pkg::RSP_PROMOTE:
            begin
                result_id_next    = id_reg;
                priority_out_next = prio_inc;
            end
            ptp_pkg::RSP_GET:
            begin
                result_id_next    = id_reg;
                payload_out_next  = pay_rd_reg;
                priority_out_next = prio_rd_reg;
            end
            ptp_pkg::RSP_VALID:
            begin
                is_live_next = id_live;
            end
            ptp_pkg::RSP_EMPTY:
            begin
                status_next = ptp_pkg::ST_EMPTY;
            end
            ptp_pkg::RSP_MAX:
            begin
                result_id_next    = best_id_reg;
                payload_out_next  = pay_rd_reg;
                priority_out_next = prio_rd_reg;
            end
            default:
            begin
                status_next = ptp_pkg::ST_INVALID;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.respond;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.respond)
        begin
            status_reg       <= status_next;
            result_id_reg    <= result_id_next;
            payload_out_reg  <= payload_out_next;
            priority_out_reg <= priority_out_next;
            is_live_reg      <= is_live_next;
        end
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign result_id    = result_id_reg;
    assign payload_out  = payload_out_reg;
    assign priority_out = priority_out_reg;
    assign is_live      = is_live_reg;

endmodule

// ===== src/ptp_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Priority table controller
// Sequences decode, memory reads, the max scan and the result beat.
// ----------------------------------------------------------------------------
module ptp_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  ptp_pkg::stat_t stat,
    output ptp_pkg::cmd_t  cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_READ   = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_DRAIN  = 3'd4;
    localparam logic [2:0] S_FETCH  = 3'd5;
    localparam logic [2:0] S_MAXOUT = 3'd6;

    logic [2:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.rd_sel     = ptp_pkg::RD_ID;
        cmd.resp_sel   = ptp_pkg::RSP_BAD_OP;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_IDLE;
                case (stat.op)
                    ptp_pkg::OP_ADD:
                    begin
                        cmd.respond = 1'b1;
                        if (stat.full)
                        begin
                            cmd.resp_sel = ptp_pkg::RSP_FULL;
                        end
                        else
                        begin
                            cmd.resp_sel   = ptp_pkg::RSP_ADD_OK;
                            cmd.add_commit = 1'b1;
                        end
                    end
                    ptp_pkg::OP_PROMOTE, ptp_pkg::OP_GET:
                    begin
                        if (stat.id_live)
                        begin
                            cmd.rd_en  = 1'b1;
                            state_next = S_READ;
                        end
                        else
                        begin
                            cmd.respond  = 1'b1;
                            cmd.resp_sel = ptp_pkg::RSP_BAD_ID;
                        end
                    end
                    ptp_pkg::OP_IS_VALID:
                    begin
                        cmd.respond  = 1'b1;
                        cmd.resp_sel = ptp_pkg::RSP_VALID;
                    end
                    ptp_pkg::OP_GET_MAX, ptp_pkg::OP_POP_MAX:
                    begin
                        cmd.scan_init = 1'b1;
                        state_next    = S_SCAN;
                    end
                    default:
                    begin
                        cmd.respond  = 1'b1;
                        cmd.resp_sel = ptp_pkg::RSP_BAD_OP;
                    end
                endcase
            end
            S_READ:
            begin
                cmd.respond = 1'b1;
                state_next  = S_IDLE;
                if (stat.op == ptp_pkg::OP_PROMOTE)
                begin
                    cmd.prio_wr  = 1'b1;
                    cmd.resp_sel = ptp_pkg::RSP_PROMOTE;
                end
                else
                begin
                    cmd.resp_sel = ptp_pkg::RSP_GET;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                cmd.rd_en     = 1'b1;
                cmd.rd_sel    = ptp_pkg::RD_SCAN;
                if (stat.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_FETCH;
            end
            S_FETCH:
            begin
                if (stat.found)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = ptp_pkg::RD_BEST;
                    state_next = S_MAXOUT;
                end
                else
                begin
                    cmd.respond  = 1'b1;
                    cmd.resp_sel = ptp_pkg::RSP_EMPTY;
                    state_next   = S_IDLE;
                end
            end
            S_MAXOUT:
            begin
                cmd.respond   = 1'b1;
                cmd.resp_sel  = ptp_pkg::RSP_MAX;
                cmd.pop_clear = (stat.op == ptp_pkg::OP_POP_MAX);
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Priority table core testbench
// Drives add, promote, get, is_valid, get_max and pop_max beats: a directed
// opening, a short promote run, then three random phases with varying
// sender gaps. A scoreboard keeps its own table, predicts every reply and
// checks each done strobe against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
    import ptp_pkg::*;

    localparam int CYCLE_LIMIT  = 3000000;
    localparam int PHASE_BEATS  = 445;
    localparam int PROMOTE_RUN  = 40;
    localparam int DRAIN_CYCLES = 300;

    typedef struct packed {
        logic [1:0]               status;
        logic [ADDR_BITS-1:0]     rid;
        logic [PAYLOAD_BITS-1:0]  pay;
        logic [PRIORITY_BITS-1:0] prio;
        logic                     live;
    } reply_t;

    class table_scoreboard;
        int unsigned              issued;
        logic [PAYLOAD_BITS-1:0]  payload_mem [DEPTH];
        logic [PRIORITY_BITS-1:0] prio_mem [DEPTH];
        bit                       live_mem [DEPTH];
        reply_t                   pending_replies [$];
        int                       errors;
        int                       beats;
        int                       replies;
        int                       full_seen;
        int                       empty_seen;
        int                       sat_seen;

        function new();
            issued = 0;
            foreach (live_mem[i]) live_mem[i] = 1'b0;
            errors = 0;
            beats = 0;
            replies = 0;
            full_seen = 0;
            empty_seen = 0;
            sat_seen = 0;
        endfunction

        function bit id_live(logic [ADDR_BITS-1:0] id);
            return (int'(id) < issued) && (int'(id) < DEPTH) && live_mem[id];
        endfunction

        function reply_t predict_reply(logic [2:0] op, logic [ADDR_BITS-1:0] id,
                                       logic [PAYLOAD_BITS-1:0] pay);
            reply_t                   r;
            int                       best;
            logic [PRIORITY_BITS-1:0] best_prio;
            r = '0;
            best = -1;
            best_prio = '0;
            case (op)
                OP_ADD:
                begin
                    if (issued >= DEPTH)
                    begin
                        r.status = ST_FULL;
                        full_seen++;
                    end
                    else
                    begin
                        payload_mem[issued] = pay;
                        prio_mem[issued] = '0;
                        live_mem[issued] = 1'b1;
                        r.status = ST_OK;
                        r.rid = ADDR_BITS'(issued);
                        issued++;
                    end
                end
                OP_PROMOTE:
                begin
                    r.rid = id;
                    if (!id_live(id))
                        r.status = ST_INVALID;
                    else
                    begin
                        if (prio_mem[id] != '1)
                            prio_mem[id] = prio_mem[id] + 1'b1;
                        else
                            sat_seen++;
                        r.status = ST_OK;
                        r.prio = prio_mem[id];
                    end
                end
                OP_GET:
                begin
                    r.rid = id;
                    if (!id_live(id))
                        r.status = ST_INVALID;
                    else
                    begin
                        r.status = ST_OK;
                        r.pay = payload_mem[id];
                        r.prio = prio_mem[id];
                    end
                end
                OP_IS_VALID:
                begin
                    r.status = ST_OK;
                    r.live = id_live(id);
                end
                OP_GET_MAX, OP_POP_MAX:
                begin
                    for (int i = 0; i < DEPTH; i++)
                    begin
                        if (live_mem[i] && (best < 0 || prio_mem[i] >= best_prio))
                        begin
                            best = i;
                            best_prio = prio_mem[i];
                        end
                    end
                    if (best < 0)
                    begin
                        r.status = ST_EMPTY;
                        empty_seen++;
                    end
                    else
                    begin
                        r.status = ST_OK;
                        r.rid = ADDR_BITS'(best);
                        r.pay = payload_mem[best];
                        r.prio = prio_mem[best];
                        if (op == OP_POP_MAX)
                            live_mem[best] = 1'b0;
                    end
                end
                default:
                    r.status = ST_INVALID;
            endcase
            return r;
        endfunction

        function void note_beat(logic [2:0] op, logic [ADDR_BITS-1:0] id,
                                logic [PAYLOAD_BITS-1:0] pay);
            pending_replies.push_back(predict_reply(op, id, pay));
            beats++;
        endfunction

        function void check_reply(reply_t got);
            reply_t want;
            if (pending_replies.size() == 0)
            begin
                $error("unexpected reply: status %0d result_id %0d", got.status, got.rid);
                errors++;
                return;
            end
            want = pending_replies.pop_front();
            replies++;
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.rid !== want.rid)
            begin
                $error("result_id: expected %0d, got %0d", want.rid, got.rid);
                errors++;
            end
            if (got.pay !== want.pay)
            begin
                $error("payload_out: expected %h, got %h", want.pay, got.pay);
                errors++;
            end
            if (got.prio !== want.prio)
            begin
                $error("priority_out: expected %0d, got %0d", want.prio, got.prio);
                errors++;
            end
            if (got.live !== want.live)
            begin
                $error("is_live: expected %0d, got %0d", want.live, got.live);
                errors++;
            end
        endfunction
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic [2:0]               opcode = '0;
    logic [ADDR_BITS-1:0]     entry_id = '0;
    logic [PAYLOAD_BITS-1:0]  payload_in = '0;
    logic                     busy;
    logic                     done;
    logic [1:0]               status;
    logic [ADDR_BITS-1:0]     result_id;
    logic [PAYLOAD_BITS-1:0]  payload_out;
    logic [PRIORITY_BITS-1:0] priority_out;
    logic                     is_live;

    table_scoreboard sb = new();
    int unsigned     cycles = 0;

    priority_table_with_promote_core dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .entry_id     (entry_id),
        .payload_in   (payload_in),
        .done         (done),
        .status       (status),
        .result_id    (result_id),
        .payload_out  (payload_out),
        .priority_out (priority_out),
        .is_live      (is_live)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("priority_table_with_promote_core test failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_reply('{status, result_id, payload_out, priority_out, is_live});
    end

    // Hold the beat until an edge with busy low.
    task automatic send_beat(input logic [2:0] op, input logic [ADDR_BITS-1:0] id,
                             input logic [PAYLOAD_BITS-1:0] pay);
        opcode <= op;
        entry_id <= id;
        payload_in <= pay;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_beat(op, id, pay);
    endtask

    task automatic sender_gap(input int pct);
        if ($urandom_range(0, 99) < pct)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < pct);
        end
    endtask

    task automatic random_beat();
        int                   pick;
        logic [2:0]           op;
        logic [ADDR_BITS-1:0] id;
        pick = $urandom_range(0, 99);
        if (pick < 24)
            op = OP_ADD;
        else if (pick < 54)
            op = OP_PROMOTE;
        else if (pick < 66)
            op = OP_GET;
        else if (pick < 75)
            op = OP_IS_VALID;
        else if (pick < 86)
            op = OP_GET_MAX;
        else if (pick < 97)
            op = OP_POP_MAX;
        else
            op = 3'($urandom_range(6, 7));
        if (sb.issued > 0 && $urandom_range(0, 9) < 8)
            id = ADDR_BITS'($urandom_range(0, sb.issued - 1));
        else
            id = ADDR_BITS'($urandom);
        send_beat(op, id, $urandom);
    endtask

    initial
    begin
        int pct [3];
        pct = '{29, 83, 0};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // empty table, out-of-range ids, unused opcodes
        send_beat(OP_GET_MAX, '0, '0);
        send_beat(OP_POP_MAX, '0, '0);
        send_beat(OP_GET, '0, '0);
        send_beat(OP_PROMOTE, '0, '0);
        send_beat(OP_IS_VALID, '0, '0);
        send_beat(OP_IS_VALID, '1, '1);
        send_beat(3'd6, '1, '1);
        send_beat(3'd7, '1, '1);
        // payload extremes, ties, promote, pop, dead entries
        send_beat(OP_ADD, '1, '0);
        send_beat(OP_ADD, '0, '1);
        send_beat(OP_ADD, '0, 32'h5a5a_a5a5);
        send_beat(OP_GET, 8'd0, '0);
        send_beat(OP_GET, 8'd1, '0);
        send_beat(OP_IS_VALID, 8'd1, '0);
        send_beat(OP_IS_VALID, 8'd3, '0);
        send_beat(OP_GET_MAX, '0, '0);
        send_beat(OP_PROMOTE, 8'd0, '0);
        send_beat(OP_GET_MAX, '0, '0);
        send_beat(OP_POP_MAX, '0, '0);
        send_beat(OP_GET, 8'd0, '0);
        send_beat(OP_PROMOTE, 8'd0, '0);
        send_beat(OP_IS_VALID, 8'd0, '0);
        send_beat(OP_GET_MAX, '0, '0);

        // climb one entry up a run of priorities
        send_beat(OP_ADD, '0, 32'hc3c3_3c3c);
        repeat (PROMOTE_RUN)
            send_beat(OP_PROMOTE, 8'd3, '0);
        send_beat(OP_GET, 8'd3, '0);
        send_beat(OP_POP_MAX, '0, '0);

        foreach (pct[p])
        begin
            repeat (PHASE_BEATS)
            begin
                sender_gap(pct[p]);
                random_beat();
            end
        end
        start <= 1'b0;

        while (sb.pending_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d beats and %0d replies; %0d ids issued.",
                 sb.beats, sb.replies, sb.issued);
        $display("Full replies %0d, empty replies %0d, saturated promotes %0d.",
                 sb.full_seen, sb.empty_seen, sb.sat_seen);
        if (sb.errors == 0)
            $display("priority_table_with_promote_core test passed");
        else
            $display("priority_table_with_promote_core test failed");
        $finish;
    end
endmodule
